FILE: src/assert_macros.svh
// assertion macros shared by the interrupt entry unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("interrupt entry unit: property violated");

// condition that must never be seen out of reset
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("interrupt entry unit: forbidden condition seen");

`endif

FILE: src/dieu_pkg.sv
// types, codes and constants of the interrupt entry unit
`default_nettype none

package dieu_pkg;

    // number of lines that a raise by number may set
    localparam int IRQ_COUNT     = 32;
    // global mask bit in status1
    localparam int INTM_POSITION = 11;
    // depth of the queue between front and back, power of two
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    // operation codes of an input transaction
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_RAISE = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VECTOR_BASE = 2'd0;
    localparam logic [1:0] CFG_HIGH_SHIFT  = 2'd1;
    localparam logic [1:0] CFG_LOW_SHIFT   = 2'd2;

    // reserved line that a level event ignores (besides lines 0 and 1)
    localparam logic [5:0] RESERVED_LINE = 6'd10;

    // status0 bits kept on the system stack
    localparam logic [15:0] ST0_SAVE_MASK = 16'hFE00;

    // entry runs seven results: six stack writes then the vector
    localparam logic [2:0] LAST_STEP = 3'd6;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_STACK  = 2'd1,
        KIND_VECTOR = 2'd2,
        KIND_LINE   = 2'd3
    } kind_t;

    // class of a queued transaction as decided by the front
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_LINE  = 2'd1,
        CLS_ENTRY = 2'd2
    } cls_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  irq_index;
        logic        level;
        logic [23:0] pc_value;
        logic [22:0] data_stack;
        logic [22:0] system_stack;
        logic [15:0] status0;
        logic [15:0] status1;
        logic [15:0] status2;
        logic [15:0] debug_status;
        logic [31:0] enable_mask;
        logic        in_service;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] address;
        logic [15:0] data;
        logic [4:0]  taken_line;
        logic [22:0] new_data_stack;
        logic [22:0] new_system_stack;
        logic [15:0] new_status1;
        logic [31:0] debug_enables;
        logic        last;
    } out_item_t;

    // classified transaction passed from front to back
    typedef struct packed {
        cls_t        cls;
        logic [4:0]  line;
        logic [23:0] pc;
        logic [22:0] sp;
        logic [22:0] ssp;
        logic [15:0] st0;
        logic [15:0] st1;
        logic [15:0] st2;
        logic [15:0] dbst;
        logic [31:0] dbg;
    } rec_t;

    // configuration write as seen by the back
    typedef struct packed {
        logic        wr;
        logic [1:0]  index;
        logic [23:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

FILE: src/dieu_front.sv
// front: accepts transactions, keeps pending and debug enable flags, classifies
`default_nettype none
`include "assert_macros.svh"

module dieu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire dieu_pkg::in_item_t in_item,
    input  wire logic              q_full,
    output logic                   in_ready,
    output logic                   push,
    output dieu_pkg::rec_t         rec
);

    localparam logic [5:0] RESERVED_LINE_C = dieu_pkg::RESERVED_LINE;
    localparam logic [6:0] IRQ_LIMIT       = 7'(dieu_pkg::IRQ_COUNT);

    logic [31:0] pending_reg;
    logic [31:0] pending_next;
    logic [31:0] dbg_reg;
    logic [31:0] dbg_next;
    logic [31:0] cand;
    logic [4:0]  low_line;
    logic        line_ok;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // lowest pending line from 2 upward
    assign cand = pending_reg & ~32'd3;
    always_comb
    begin
        low_line = 5'd2;
        for (int i = 31; i >= 2; i--)
        begin
            if (cand[i])
            begin
                low_line = 5'(i);
            end
        end
    end

    // level events skip reserved lines
    assign line_ok = (in_item.irq_index[5] == 1'b0) && (in_item.irq_index != 6'd0)
                     && (in_item.irq_index != 6'd1) && (in_item.irq_index != RESERVED_LINE_C);

    // classify and compute next flag state
    always_comb
    begin
        pending_next = pending_reg;
        dbg_next     = dbg_reg;
        rec.cls      = dieu_pkg::CLS_NONE;
        rec.line     = 5'd0;
        case (in_item.op)
            dieu_pkg::OP_LINE:
            begin
                rec.cls = dieu_pkg::CLS_LINE;
                if (line_ok)
                begin
                    pending_next[in_item.irq_index[4:0]] = in_item.level;
                end
            end
            dieu_pkg::OP_RAISE:
            begin
                rec.cls = dieu_pkg::CLS_LINE;
                if ({1'b0, in_item.irq_index} < IRQ_LIMIT && !in_item.irq_index[5])
                begin
                    pending_next[in_item.irq_index[4:0]] = 1'b1;
                end
            end
            dieu_pkg::OP_CHECK:
            begin
                if (!in_item.in_service && cand != 32'd0)
                begin
                    pending_next[low_line] = 1'b0;
                    if (in_item.enable_mask[low_line]
                        && !in_item.status1[dieu_pkg::INTM_POSITION])
                    begin
                        rec.cls            = dieu_pkg::CLS_ENTRY;
                        rec.line           = low_line;
                        dbg_next[low_line] = 1'b1;
                    end
                end
            end
            default:
            begin
                rec.cls = dieu_pkg::CLS_NONE;
            end
        endcase
        rec.pc   = in_item.pc_value;
        rec.sp   = in_item.data_stack;
        rec.ssp  = in_item.system_stack;
        rec.st0  = in_item.status0;
        rec.st1  = in_item.status1;
        rec.st2  = in_item.status2;
        rec.dbst = in_item.debug_status;
        rec.dbg  = dbg_next;
    end

    // flag registers change only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            dbg_reg     <= '0;
        end
        else if (push)
        begin
            pending_reg <= pending_next;
            dbg_reg     <= dbg_next;
        end
    end

    `ASSERT_AT(a_entry_sets_dbg,
        push && rec.cls == dieu_pkg::CLS_ENTRY |=> dbg_reg[$past(rec.line)])
    `ASSERT_AT(a_entry_clears_pend,
        push && rec.cls == dieu_pkg::CLS_ENTRY |=> !pending_reg[$past(rec.line)])

endmodule

`default_nettype wire

FILE: src/dieu_queue.sv
// short queue of classified transactions between front and back
`default_nettype none
`include "assert_macros.svh"

module dieu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dieu_pkg::rec_t push_rec,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output dieu_pkg::rec_t      head
);

    localparam int PW = dieu_pkg::QPTR_W;
    localparam int CW = dieu_pkg::QCNT_W;
    localparam logic [CW-1:0] DEPTH = CW'(dieu_pkg::QDEPTH);

    dieu_pkg::rec_t mem [dieu_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full       = (count_reg == DEPTH);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    `ASSERT_NEVER(a_count_range, count_reg > DEPTH)
    `ASSERT_NEVER(a_pop_empty, pop && !head_valid)

endmodule

`default_nettype wire

FILE: src/dieu_back.sv
// back: holds configuration and plays out the results of each transaction
`default_nettype none
`include "assert_macros.svh"

module dieu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dieu_pkg::cfg_wr_t cfg,
    input  wire logic            head_valid,
    input  wire dieu_pkg::rec_t  head,
    output logic                 pop,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output dieu_pkg::out_item_t  out_item
);

    logic [23:0]         vector_base_reg;
    logic [15:0]         high_shift_reg;
    logic [15:0]         low_shift_reg;
    logic [2:0]          step_reg;
    logic [2:0]          step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    dieu_pkg::out_item_t out_item_reg;
    dieu_pkg::out_item_t res;
    logic                load;
    logic                res_last;
    logic [22:0]         dec;
    logic [22:0]         stack_base;
    logic [22:0]         sp3;
    logic [22:0]         ssp3;
    logic [24:0]         vec_sum;
    logic [23:0]         vec_sh;
    logic [15:0]         shift;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = load && res_last;

    // stack pointers after the save and the current write address
    assign sp3        = head.sp - 23'd3;
    assign ssp3       = head.ssp - 23'd3;
    assign dec        = 23'(step_reg[2:1]) + 23'd1;
    assign stack_base = step_reg[0] ? head.ssp : head.sp;

    // vector address, lines 16 to 23 use the high shift
    assign shift   = (head.line[4:3] == 2'b10) ? high_shift_reg : low_shift_reg;
    assign vec_sum = {1'b0, vector_base_reg} + {17'd0, head.line, 3'd0};
    assign vec_sh  = 24'(vec_sum >> shift[4:0]);

    // result for the current step of the head transaction
    always_comb
    begin
        res_last             = 1'b1;
        res.kind             = dieu_pkg::KIND_NONE;
        res.address          = 24'd0;
        res.data             = 16'd0;
        res.taken_line       = 5'd0;
        res.new_data_stack   = head.sp;
        res.new_system_stack = head.ssp;
        res.new_status1      = head.st1;
        res.debug_enables    = head.dbg;
        res.last             = 1'b1;
        case (head.cls)
            dieu_pkg::CLS_LINE:
            begin
                res.kind = dieu_pkg::KIND_LINE;
            end
            dieu_pkg::CLS_ENTRY:
            begin
                res_last             = (step_reg == dieu_pkg::LAST_STEP);
                res.last             = res_last;
                res.taken_line       = head.line;
                res.new_data_stack   = sp3;
                res.new_system_stack = ssp3;
                res.new_status1      = head.st1;
                res.new_status1[dieu_pkg::INTM_POSITION] = 1'b1;
                if (res_last)
                begin
                    res.kind    = dieu_pkg::KIND_VECTOR;
                    res.address = (shift[15:5] != 11'd0) ? 24'd0 : vec_sh;
                end
                else
                begin
                    res.kind    = dieu_pkg::KIND_STACK;
                    res.address = {1'b0, stack_base - dec};
                end
                case (step_reg)
                    3'd0:    res.data = head.st2;
                    3'd1:    res.data = head.st0 & dieu_pkg::ST0_SAVE_MASK;
                    3'd2:    res.data = head.st1;
                    3'd3:    res.data = head.dbst;
                    3'd4:    res.data = head.pc[15:0];
                    3'd5:    res.data = {8'd0, head.pc[23:16]};
                    default: res.data = 16'd0;
                endcase
            end
            default:
            begin
                res.kind = dieu_pkg::KIND_NONE;
            end
        endcase
    end

    // step counter and output valid
    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = res_last ? 3'd0 : step_reg + 3'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= 3'd0;
            out_valid_reg   <= 1'b0;
            vector_base_reg <= 24'd0;
            high_shift_reg  <= 16'd0;
            low_shift_reg   <= 16'd0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.wr)
            begin
                case (cfg.index)
                    dieu_pkg::CFG_VECTOR_BASE: vector_base_reg <= cfg.data;
                    dieu_pkg::CFG_HIGH_SHIFT:  high_shift_reg  <= cfg.data[15:0];
                    dieu_pkg::CFG_LOW_SHIFT:   low_shift_reg   <= cfg.data[15:0];
                    default:                   vector_base_reg <= vector_base_reg;
                endcase
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= res;
        end
    end

    `ASSERT_NEVER(a_step_range, step_reg > dieu_pkg::LAST_STEP)
    `ASSERT_AT(a_step_in_entry, step_reg != 3'd0 |-> head_valid && head.cls == dieu_pkg::CLS_ENTRY)

endmodule

`default_nettype wire

FILE: src/dsp_interrupt_entry_unit.sv
// top level of the interrupt entry unit: front, queue and back
//
// Input channel in_valid/in_ready/in_item carries line events, raises by
// number and instruction boundary checks. Output channel out_valid/out_ready/
// out_item returns results; last marks the final result of a transaction.
// Configuration writes go through cfg_valid/cfg_ready/cfg_index/cfg_data,
// always ready, index 0 vector base, 1 high vector shift, 2 low vector shift.
// A transaction's first result passes the queue and then the back's output
// register. Line events, raises and checks that take nothing give one result
// each and sustain one transaction per cycle with out_ready high. An interrupt
// entry gives seven results through the single output register of the back,
// one per cycle with out_ready high. A two-entry queue lets the front keep
// accepting while the back plays out an entry; when the queue is full,
// in_ready drops. When the receiver stalls, the output register holds its
// result and the back and then the queue stop. Reset clears the pending and
// debug enable flags, the configuration registers, the queue and the output.
`default_nettype none

module dsp_interrupt_entry_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dieu_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dieu_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [23:0]         cfg_data
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              head_valid;
    dieu_pkg::rec_t    push_rec;
    dieu_pkg::rec_t    head;
    dieu_pkg::cfg_wr_t cfg;

    // configuration transaction
    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    dieu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .q_full   (q_full),
        .in_ready (in_ready),
        .push     (push),
        .rec      (push_rec)
    );

    dieu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    dieu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// testbench for the interrupt entry unit: directed, vector setting, random and backpressure tests
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 360;
    localparam int PHASES       = 4;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    dieu_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dieu_pkg::out_item_t out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = dieu_pkg::CFG_VECTOR_BASE;
    logic [23:0]         cfg_data = '0;

    // own copy of the unit's flags and registers
    logic [31:0] pend_flags = '0;
    logic [31:0] dbg_enables = '0;
    logic [23:0] vec_base = '0;
    logic [15:0] high_shift = '0;
    logic [15:0] low_shift = '0;

    // results still owed by the unit, oldest first
    dieu_pkg::out_item_t due_results[$];

    int unsigned errors = 0;
    int unsigned accepted_count = 0;
    int unsigned result_count = 0;
    int unsigned entry_count = 0;
    int unsigned cycle_count = 0;

    // idling control and long receiver hold request
    logic        idle_on = 1'b1;
    logic        hold_toggle = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned ready_hold = 0;

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dsp_interrupt_entry_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    // works out the results of one transaction and queues them
    function automatic void compute_entry_results(input dieu_pkg::in_item_t it);
        dieu_pkg::out_item_t r;
        logic [31:0] cand;
        logic [4:0]  line;
        logic [15:0] shift;
        logic [31:0] sum;
        logic [22:0] ds_addr[3];
        logic [22:0] ss_addr[3];
        logic [15:0] words[6];
        r = '0;
        r.kind = dieu_pkg::KIND_NONE;
        r.new_data_stack = it.data_stack;
        r.new_system_stack = it.system_stack;
        r.new_status1 = it.status1;
        r.last = 1'b1;
        cand = pend_flags & ~32'd3;
        line = 5'd2;
        if (it.op == dieu_pkg::OP_LINE)
        begin
            // reserved lines and numbers past 31 leave the flags alone
            if (it.irq_index < 6'd32 && it.irq_index > 6'd1
                && it.irq_index != dieu_pkg::RESERVED_LINE)
                pend_flags[it.irq_index[4:0]] = it.level;
            r.kind = dieu_pkg::KIND_LINE;
        end
        else if (it.op == dieu_pkg::OP_RAISE)
        begin
            if (int'(it.irq_index) < dieu_pkg::IRQ_COUNT && it.irq_index < 6'd32)
                pend_flags[it.irq_index[4:0]] = 1'b1;
            r.kind = dieu_pkg::KIND_LINE;
        end
        else if (it.op == dieu_pkg::OP_CHECK && !it.in_service && cand != '0)
        begin
            // lowest pending line from 2 upward, always cleared
            while (line < 5'd31 && !cand[line])
                line++;
            pend_flags[line] = 1'b0;
            if (it.enable_mask[line] && !it.status1[dieu_pkg::INTM_POSITION])
            begin
                dbg_enables[line] = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    ds_addr[i] = it.data_stack - 23'(i + 1);
                    ss_addr[i] = it.system_stack - 23'(i + 1);
                end
                words = '{it.status2, it.status0 & dieu_pkg::ST0_SAVE_MASK, it.status1,
                          it.debug_status, it.pc_value[15:0],
                          {8'h00, it.pc_value[23:16]}};
                r.taken_line = line;
                r.new_data_stack = ds_addr[2];
                r.new_system_stack = ss_addr[2];
                r.new_status1 = it.status1;
                r.new_status1[dieu_pkg::INTM_POSITION] = 1'b1;
                r.debug_enables = dbg_enables;
                r.last = 1'b0;
                r.kind = dieu_pkg::KIND_STACK;
                // context words alternate between data and system stack
                for (int i = 0; i < 6; i++)
                begin
                    r.address = (i % 2 == 0) ? {1'b0, ds_addr[i / 2]} : {1'b0, ss_addr[i / 2]};
                    r.data = words[i];
                    due_results.push_back(r);
                end
                // vector address from base and line, shifted per line group
                shift = (line >= 5'd16 && line <= 5'd23) ? high_shift : low_shift;
                sum = 32'(vec_base) + 32'(line) * 32'd8;
                r.kind = dieu_pkg::KIND_VECTOR;
                r.address = (shift >= 16'd32) ? 24'd0 : 24'(sum >> shift);
                r.data = '0;
                r.last = 1'b1;
                due_results.push_back(r);
                return;
            end
        end
        r.debug_enables = dbg_enables;
        due_results.push_back(r);
    endfunction

    // record accepted transactions and register writes
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            compute_entry_results(in_item);
            accepted_count++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dieu_pkg::CFG_VECTOR_BASE: vec_base = cfg_data;
                dieu_pkg::CFG_HIGH_SHIFT:  high_shift = cfg_data[15:0];
                dieu_pkg::CFG_LOW_SHIFT:   low_shift = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        dieu_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, out_item);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                if (want.kind == dieu_pkg::KIND_VECTOR)
                    entry_count++;
                check_field("kind", want.kind, out_item.kind);
                check_field("address", want.address, out_item.address);
                check_field("data", want.data, out_item.data);
                check_field("taken_line", want.taken_line, out_item.taken_line);
                check_field("new_data_stack", want.new_data_stack, out_item.new_data_stack);
                check_field("new_system_stack", want.new_system_stack,
                            out_item.new_system_stack);
                check_field("new_status1", want.new_status1, out_item.new_status1);
                check_field("debug_enables", want.debug_enables, out_item.debug_enables);
                check_field("last", want.last, out_item.last);
            end
        end
    end

    // result receiver: random stalls plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            ready_hold <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            ready_hold <= gap_len() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // run timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic dieu_pkg::in_item_t rand_item();
        dieu_pkg::in_item_t it;
        it.op = 2'($urandom_range(0, 3));
        it.irq_index = 6'($urandom());
        it.level = 1'($urandom());
        it.pc_value = 24'($urandom());
        it.data_stack = 23'($urandom());
        it.system_stack = 23'($urandom());
        it.status0 = 16'($urandom());
        it.status1 = 16'($urandom());
        it.status2 = 16'($urandom());
        it.debug_status = 16'($urandom());
        it.enable_mask = $urandom();
        it.in_service = 1'($urandom());
        return it;
    endfunction

    // random content, but mostly unmasked, enabled and not in service
    function automatic dieu_pkg::in_item_t make_item(input logic [1:0] op,
                                                     input int unsigned idx,
                                                     input int unsigned lvl);
        dieu_pkg::in_item_t it;
        it = rand_item();
        it.op = op;
        it.irq_index = 6'(idx);
        it.level = 1'(lvl);
        it.status1[dieu_pkg::INTM_POSITION] = ($urandom_range(0, 7) == 0);
        it.in_service = ($urandom_range(0, 7) == 0);
        it.enable_mask = $urandom() | $urandom();
        return it;
    endfunction

    // boundary check that takes any pending line
    function automatic dieu_pkg::in_item_t open_check();
        dieu_pkg::in_item_t it;
        it = make_item(dieu_pkg::OP_CHECK, 0, 0);
        it.in_service = 1'b0;
        it.status1[dieu_pkg::INTM_POSITION] = 1'b0;
        it.enable_mask = '1;
        return it;
    endfunction

    // valid stays high into the next transaction unless a gap is drawn
    task automatic send_item(input dieu_pkg::in_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [23:0] base, input logic [15:0] hi,
                              input logic [15:0] lo);
        logic [1:0]  regs[3];
        logic [23:0] vals[3];
        regs = '{dieu_pkg::CFG_VECTOR_BASE, dieu_pkg::CFG_HIGH_SHIFT, dieu_pkg::CFG_LOW_SHIFT};
        vals = '{base, {8'h00, hi}, {8'h00, lo}};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // reserved lines, ignored raises, masking, priority and stack wrap
    task automatic test_directed_cases();
        dieu_pkg::in_item_t it;
        int unsigned ignored_lines[4] = '{0, 1, 10, 40};
        // nothing pending, then the unused op code
        send_item(open_check());
        it = rand_item();
        it.op = OP_UNUSED;
        send_item(it);
        foreach (ignored_lines[i])
            send_item(make_item(dieu_pkg::OP_LINE, ignored_lines[i], 1));
        send_item(make_item(dieu_pkg::OP_RAISE, 63, 0));
        // bits 0 and 1 alone take nothing
        send_item(make_item(dieu_pkg::OP_RAISE, 0, 0));
        send_item(make_item(dieu_pkg::OP_RAISE, 1, 0));
        send_item(open_check());
        // level high then low leaves nothing pending
        send_item(make_item(dieu_pkg::OP_LINE, 5, 1));
        send_item(make_item(dieu_pkg::OP_LINE, 5, 0));
        send_item(open_check());
        // busy, masked and disabled checks
        send_item(make_item(dieu_pkg::OP_RAISE, 31, 1));
        it = open_check();
        it.in_service = 1'b1;
        send_item(it);
        it = open_check();
        it.status1[dieu_pkg::INTM_POSITION] = 1'b1;
        send_item(it);
        send_item(make_item(dieu_pkg::OP_RAISE, 31, 1));
        it = open_check();
        it.enable_mask[31] = 1'b0;
        send_item(it);
        send_item(make_item(dieu_pkg::OP_RAISE, 31, 1));
        send_item(open_check());
        // lowest line wins
        send_item(make_item(dieu_pkg::OP_RAISE, 3, 1));
        send_item(make_item(dieu_pkg::OP_LINE, 2, 1));
        send_item(open_check());
        send_item(open_check());
        // all-ones fields with stack pointers wrapping below zero
        send_item(make_item(dieu_pkg::OP_LINE, 16, 1));
        it = open_check();
        it.data_stack = '0;
        it.system_stack = 23'd1;
        it.pc_value = '1;
        it.status0 = '1;
        it.status1 = 16'hFFFF;
        it.status1[dieu_pkg::INTM_POSITION] = 1'b0;
        it.status2 = '1;
        it.debug_status = '1;
        send_item(it);
        // all-zero fields
        send_item(make_item(dieu_pkg::OP_RAISE, 23, 1));
        it = '0;
        it.op = dieu_pkg::OP_CHECK;
        it.enable_mask = '1;
        send_item(it);
    endtask

    // vector address across base and shift extremes, both line groups
    task automatic test_vector_settings();
        logic [23:0] bases[5];
        logic [15:0] his[5];
        logic [15:0] los[5];
        int unsigned lines[6] = '{2, 15, 16, 23, 24, 31};
        bases = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h5A5A5A, 24'($urandom())};
        his = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'($urandom_range(0, 33))};
        los = '{16'd0, 16'd31, 16'd32, 16'd2, 16'($urandom_range(0, 33))};
        for (int s = 0; s < 5; s++)
        begin
            wait_idle();
            set_config(bases[s], his[s], los[s]);
            foreach (lines[i])
            begin
                send_item(make_item(dieu_pkg::OP_RAISE, lines[i], 1));
                send_item(open_check());
            end
        end
    endtask

    // mostly raises and checks with random content, plus line events and noise
    task automatic test_random_traffic();
        dieu_pkg::in_item_t it;
        int unsigned pick;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            set_config(24'($urandom()),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12)),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12)));
            // one phase runs without any idling
            idle_on <= (phase != 2);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    it = make_item(dieu_pkg::OP_RAISE, $urandom_range(0, 31), 1);
                else if (pick < 50)
                    it = make_item(dieu_pkg::OP_LINE, $urandom_range(0, 35),
                                   $urandom_range(0, 1));
                else if (pick < 90)
                    it = make_item(dieu_pkg::OP_CHECK, $urandom_range(0, 63),
                                   $urandom_range(0, 1));
                else
                    it = rand_item();
                send_item(it);
            end
        end
        idle_on <= 1'b1;
    endtask

    // receiver holds off while entries keep coming, so the input stalls
    task automatic test_backpressure();
        wait_idle();
        idle_on <= 1'b0;
        hold_toggle <= ~hold_toggle;
        for (int n = 0; n < 15; n++)
        begin
            send_item(make_item(dieu_pkg::OP_RAISE, $urandom_range(2, 31), 1));
            send_item(open_check());
        end
        idle_on <= 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_vector_settings();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        $display("tb: %0d transactions in, %0d results checked, %0d interrupt entries",
                 accepted_count, result_count, entry_count);
        $display("tb: covered reserved lines, masking, shift extremes, stalls and a long hold");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
